// ----- src/tbem_pkg.sv -----
// Shared constants, codes and types of the token budget event mailbox.
package tbem_pkg;

  localparam int unsigned QUEUE_DEPTH      = 16;
  localparam int unsigned TAG_BITS         = 32;
  localparam int unsigned MAX_DELTA_TOKENS = 4095;

  localparam int unsigned TOK_W   = 12;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned BUDGET_W = 16;
  localparam int unsigned MAXE_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
  localparam int unsigned ENTRY_W = TOK_W + TAG_BITS;

  localparam logic [MAXE_W-1:0]   MAX_ENTRIES_RST = MAXE_W'(16);
  localparam logic [BUDGET_W-1:0] MAX_TOKENS_RST  = BUDGET_W'(4096);

  typedef enum logic [1:0] {
    ACT_PUSH_DELTA    = 2'd0,
    ACT_PUSH_TERMINAL = 2'd1,
    ACT_POP           = 2'd2,
    ACT_CLOSE         = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_REFUSED  = 3'd1,
    ST_DELTA    = 3'd2,
    ST_TERMINAL = 3'd3,
    ST_CLOSED   = 3'd4,
    ST_NOTHING  = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ENTRIES = 2'd0,
    REG_MAX_TOKENS  = 2'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

endpackage

// ----- src/token_budget_event_mailbox.sv -----
// Token budget event mailbox: bounded delta queue in a RAM, terminal slot and flags.
//
//  channel  direction  handshake               payload
//  -------  ---------  ----------------------  ------------------------------------------
//  in       input      in_valid_i / in_stall_o  action, token_count, delta_tag, terminal_code
//  out      output     out_valid_o / out_stall_i status, counts, tag, terminal code, lease
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// In the cycle a word is taken the head entry of the queue RAM is read; in the execute
// state the result is formed from the registered read data and a pushed delta is written
// at the tail, so one word is in flight at a time.
// The execute cycle stretches for as long as the output register holds an untaken word.
// Reset clears all pointers, counters and flags; the queue RAM is not cleared, since
// the entry count keeps every read on entries that were written before.
// The configuration port is always ready and takes writes in any cycle.
module token_budget_event_mailbox (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            action_i,
  input  logic [tbem_pkg::TOK_W-1:0]            token_count_i,
  input  logic [tbem_pkg::TAG_BITS-1:0]         delta_tag_i,
  input  logic [tbem_pkg::CODE_W-1:0]           terminal_code_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [2:0]                            status_o,
  output logic [tbem_pkg::TOK_W-1:0]            out_token_count_o,
  output logic [tbem_pkg::TAG_BITS-1:0]         out_tag_o,
  output logic [tbem_pkg::CODE_W-1:0]           out_terminal_code_o,
  output logic                                  lease_release_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tbem_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [tbem_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned IDX_W    = tbem_pkg::IDX_W;
  localparam int unsigned CNT_W    = tbem_pkg::CNT_W;
  localparam int unsigned CMP_W    = tbem_pkg::CMP_W;
  localparam int unsigned TOK_W    = tbem_pkg::TOK_W;
  localparam int unsigned TAG_W    = tbem_pkg::TAG_BITS;
  localparam int unsigned CODE_W   = tbem_pkg::CODE_W;
  localparam int unsigned BUDGET_W = tbem_pkg::BUDGET_W;
  localparam int unsigned MAXE_W   = tbem_pkg::MAXE_W;
  localparam int unsigned ENTRY_W  = tbem_pkg::ENTRY_W;
  localparam int unsigned DEPTH    = tbem_pkg::QUEUE_DEPTH;

  // Configuration registers.
  logic [MAXE_W-1:0]   max_entries_q;
  logic [BUDGET_W-1:0] max_tokens_q;

  // Control state.
  tbem_pkg::state_e    state_q, state_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [BUDGET_W-1:0] queued_q, queued_d;
  logic                term_pending_q, term_pending_d;
  logic                term_committed_q, term_committed_d;
  logic                closed_q, closed_d;
  logic [CODE_W-1:0]   term_value_q, term_value_d;

  // The word being executed.
  tbem_pkg::action_e   act_q;
  logic [TOK_W-1:0]    tok_q;
  logic [TAG_W-1:0]    tag_q;
  logic [CODE_W-1:0]   code_q;

  // Queue RAM with a registered read port.
  logic [ENTRY_W-1:0]  mem [DEPTH];
  logic [ENTRY_W-1:0]  rdata_q;
  logic                mem_we;
  logic [IDX_W-1:0]    tail_idx;

  // Output register.
  logic                out_valid_q;
  tbem_pkg::status_e   status_q, status_d;
  logic [TOK_W-1:0]    otok_q, otok_d;
  logic [TAG_W-1:0]    otag_q, otag_d;
  logic [CODE_W-1:0]   ocode_q, ocode_d;
  logic                olease_q, olease_d;

  logic                in_accept;
  logic                complete;
  logic [CMP_W-1:0]    entry_limit;
  logic [BUDGET_W-1:0] room;
  logic [IDX_W:0]      tail_sum;
  logic [TOK_W-1:0]    head_tok;
  logic [TAG_W-1:0]    head_tag;
  logic [BUDGET_W-1:0] head_tok_ext;
  logic [BUDGET_W-1:0] push_tok_ext;

  assign in_stall_o  = (state_q != tbem_pkg::S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign complete    = (state_q == tbem_pkg::S_EXEC) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= tbem_pkg::MAX_ENTRIES_RST;
      max_tokens_q  <= tbem_pkg::MAX_TOKENS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tbem_pkg::REG_MAX_ENTRIES: max_entries_q <= cfg_data_i[MAXE_W-1:0];
        tbem_pkg::REG_MAX_TOKENS:  max_tokens_q  <= cfg_data_i[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  // Queue RAM: the head is read when a word is taken, the tail written when an accepted push completes.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_idx] <= {tok_q, tag_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rdata_q <= mem[head_q];
    end
  end

  // Payload of the word in flight.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q  <= tbem_pkg::action_e'(action_i);
      tok_q  <= token_count_i;
      tag_q  <= delta_tag_i;
      code_q <= terminal_code_i;
    end
  end

  assign head_tok     = rdata_q[ENTRY_W-1:TAG_W];
  assign head_tag     = rdata_q[TAG_W-1:0];
  assign head_tok_ext = BUDGET_W'(head_tok);
  assign push_tok_ext = BUDGET_W'(tok_q);

  // Lower of the configured entry limit and the RAM depth.
  assign entry_limit = (CMP_W'(max_entries_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                               : CMP_W'(max_entries_q);
  assign room = (max_tokens_q > queued_q) ? (max_tokens_q - queued_q) : '0;

  // Tail sits count entries after the head, wrapping at the depth.
  assign tail_sum = (IDX_W+1)'(head_q) + (IDX_W+1)'(count_q);
  assign tail_idx = (tail_sum >= (IDX_W+1)'(DEPTH)) ? IDX_W'(tail_sum - (IDX_W+1)'(DEPTH))
                                                    : IDX_W'(tail_sum);

  always_comb begin
    head_d           = head_q;
    count_d          = count_q;
    queued_d         = queued_q;
    term_pending_d   = term_pending_q;
    term_committed_d = term_committed_q;
    closed_d         = closed_q;
    term_value_d     = term_value_q;
    status_d         = tbem_pkg::ST_REFUSED;
    otok_d           = '0;
    otag_d           = '0;
    ocode_d          = '0;
    olease_d         = 1'b0;
    mem_we           = 1'b0;
    unique case (act_q)
      tbem_pkg::ACT_PUSH_DELTA: begin
        if (tok_q != '0 && tok_q <= TOK_W'(tbem_pkg::MAX_DELTA_TOKENS)
            && !closed_q && !term_committed_q
            && CMP_W'(count_q) < entry_limit
            && push_tok_ext <= room) begin
          mem_we   = complete;
          count_d  = count_q + CNT_W'(1);
          queued_d = queued_q + push_tok_ext;
          status_d = tbem_pkg::ST_ACCEPTED;
        end
      end
      tbem_pkg::ACT_PUSH_TERMINAL: begin
        if (!closed_q && !term_committed_q) begin
          term_pending_d   = 1'b1;
          term_committed_d = 1'b1;
          term_value_d     = code_q;
          olease_d         = 1'b1;
          status_d         = tbem_pkg::ST_ACCEPTED;
        end
      end
      tbem_pkg::ACT_POP: begin
        if (count_q != '0) begin
          otok_d   = head_tok;
          otag_d   = head_tag;
          head_d   = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
          count_d  = count_q - CNT_W'(1);
          queued_d = (queued_q >= head_tok_ext) ? queued_q - head_tok_ext : '0;
          status_d = tbem_pkg::ST_DELTA;
        end else if (term_pending_q) begin
          ocode_d        = term_value_q;
          term_pending_d = 1'b0;
          closed_d       = 1'b1;
          status_d       = tbem_pkg::ST_TERMINAL;
        end else if (closed_q) begin
          status_d = tbem_pkg::ST_CLOSED;
        end else begin
          status_d = tbem_pkg::ST_NOTHING;
        end
      end
      tbem_pkg::ACT_CLOSE: begin
        closed_d = 1'b1;
        status_d = tbem_pkg::ST_ACCEPTED;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tbem_pkg::S_IDLE: if (in_accept) state_d = tbem_pkg::S_EXEC;
      tbem_pkg::S_EXEC: if (complete)  state_d = tbem_pkg::S_IDLE;
      default:          state_d = tbem_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= tbem_pkg::S_IDLE;
      head_q           <= '0;
      count_q          <= '0;
      queued_q         <= '0;
      term_pending_q   <= 1'b0;
      term_committed_q <= 1'b0;
      closed_q         <= 1'b0;
      term_value_q     <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (complete) begin
        head_q           <= head_d;
        count_q          <= count_d;
        queued_q         <= queued_d;
        term_pending_q   <= term_pending_d;
        term_committed_q <= term_committed_d;
        closed_q         <= closed_d;
        term_value_q     <= term_value_d;
        out_valid_q      <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word; it is only loaded when the register is empty or being taken.
  always_ff @(posedge clk_i) begin
    if (complete) begin
      status_q <= status_d;
      otok_q   <= otok_d;
      otag_q   <= otag_d;
      ocode_q  <= ocode_d;
      olease_q <= olease_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign out_token_count_o   = otok_q;
  assign out_tag_o           = otag_q;
  assign out_terminal_code_o = ocode_q;
  assign lease_release_o     = olease_q;

  // The queue never holds more entries than the RAM has rows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(count_q) <= CNT_W'(DEPTH))
    else $error("entry count exceeds queue depth");

  // The token sum is exact, so an empty queue carries no tokens.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (queued_q == '0))
    else $error("tokens left over in an empty queue");

  // Handing out the terminal closes the mailbox.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (complete && status_d == tbem_pkg::ST_TERMINAL) |=> closed_q)
    else $error("mailbox not closed after terminal pop");

  // A lease release only goes with an accepted terminal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && olease_q) |-> (status_q == tbem_pkg::ST_ACCEPTED))
    else $error("lease release without accepted status");

  // A taken word is executed in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == tbem_pkg::S_EXEC))
    else $error("taken word not executed");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the token budget event mailbox: stimulus, shadow model and checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is ended by the watchdog if this many cycles pass without any handshake.
  localparam int unsigned STALL_LIMIT  = 5000;
  // Least number of random words between the opening directed words and the closing sequence.
  localparam int unsigned RANDOM_WORDS = 1400;
  // Length of the single long receiver hold-off, and the reply count at which it starts.
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_AFTER   = 500;

  // One reply word as the output channel presents it.
  typedef struct packed {
    tbem_pkg::status_e                status;
    logic [tbem_pkg::TOK_W-1:0]       tokens;
    logic [tbem_pkg::TAG_BITS-1:0]    tag;
    logic [tbem_pkg::CODE_W-1:0]      code;
    logic                             lease;
  } reply_t;

  // Shadow of the mailbox: it keeps its own copy of the queue, the terminal slot, the flags
  // and the two limits, works out the reply to every word taken by the block, and compares
  // each reply that comes out against the oldest one still due.
  class mailbox_shadow;
    logic [tbem_pkg::TOK_W-1:0]    slot_tokens [tbem_pkg::QUEUE_DEPTH];
    logic [tbem_pkg::TAG_BITS-1:0] slot_tag [tbem_pkg::QUEUE_DEPTH];
    logic [tbem_pkg::IDX_W-1:0]    head_ptr;
    logic [tbem_pkg::CNT_W-1:0]    fill;
    logic [tbem_pkg::BUDGET_W-1:0] budget_used;
    logic                          term_waiting;
    logic                          term_taken;
    logic [tbem_pkg::CODE_W-1:0]   term_code;
    logic                          shut;
    logic [tbem_pkg::MAXE_W-1:0]   entry_limit;
    logic [tbem_pkg::BUDGET_W-1:0] token_budget;
    reply_t                        replies_due [$];
    int unsigned                   errors;
    int unsigned                   checked;
    int unsigned                   status_seen [6];

    function new();
      foreach (slot_tokens[i]) begin
        slot_tokens[i] = '0;
        slot_tag[i]    = '0;
      end
      head_ptr     = '0;
      fill         = '0;
      budget_used  = '0;
      term_waiting = 1'b0;
      term_taken   = 1'b0;
      term_code    = '0;
      shut         = 1'b0;
      entry_limit  = tbem_pkg::MAX_ENTRIES_RST;
      token_budget = tbem_pkg::MAX_TOKENS_RST;
      errors       = 0;
      checked      = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void write_reg(tbem_pkg::reg_idx_e idx, logic [tbem_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        tbem_pkg::REG_MAX_ENTRIES: entry_limit  = data[tbem_pkg::MAXE_W-1:0];
        tbem_pkg::REG_MAX_TOKENS:  token_budget = data[tbem_pkg::BUDGET_W-1:0];
        default: ;
      endcase
    endfunction

    // Work out the reply to one accepted word and queue it.
    function void take_word(tbem_pkg::action_e act, logic [tbem_pkg::TOK_W-1:0] tok,
                            logic [tbem_pkg::TAG_BITS-1:0] tag,
                            logic [tbem_pkg::CODE_W-1:0] code);
      reply_t                     r;
      int unsigned                cap;
      int unsigned                room;
      logic [tbem_pkg::IDX_W-1:0] tail;
      r        = '0;
      r.status = tbem_pkg::ST_REFUSED;
      // Limits above the queue depth behave as the depth; an overdrawn budget leaves no room.
      cap  = (entry_limit < tbem_pkg::QUEUE_DEPTH) ? entry_limit : tbem_pkg::QUEUE_DEPTH;
      room = (token_budget > budget_used) ? token_budget - budget_used : 0;
      case (act)
        tbem_pkg::ACT_PUSH_DELTA: begin
          if (tok != 0 && tok <= tbem_pkg::MAX_DELTA_TOKENS && !shut && !term_taken &&
              fill < cap && tok <= room) begin
            tail              = head_ptr + fill[tbem_pkg::IDX_W-1:0];
            slot_tokens[tail] = tok;
            slot_tag[tail]    = tag;
            fill++;
            budget_used += tok;
            r.status = tbem_pkg::ST_ACCEPTED;
          end
        end
        tbem_pkg::ACT_PUSH_TERMINAL: begin
          if (!shut && !term_taken) begin
            term_waiting = 1'b1;
            term_taken   = 1'b1;
            term_code    = code;
            r.lease      = 1'b1;
            r.status     = tbem_pkg::ST_ACCEPTED;
          end
        end
        tbem_pkg::ACT_POP: begin
          // Queued deltas leave first, even once the mailbox is closed.
          if (fill != 0) begin
            r.tokens    = slot_tokens[head_ptr];
            r.tag       = slot_tag[head_ptr];
            head_ptr++;
            fill--;
            budget_used = (budget_used >= r.tokens) ? budget_used - r.tokens : '0;
            r.status    = tbem_pkg::ST_DELTA;
          end else if (term_waiting) begin
            r.code       = term_code;
            term_waiting = 1'b0;
            shut         = 1'b1;
            r.status     = tbem_pkg::ST_TERMINAL;
          end else begin
            r.status = shut ? tbem_pkg::ST_CLOSED : tbem_pkg::ST_NOTHING;
          end
        end
        default: begin
          shut     = 1'b1;
          r.status = tbem_pkg::ST_ACCEPTED;
        end
      endcase
      replies_due.insert(replies_due.size(), r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: reply with status %0d arrived with none due", $time, got.status);
        return;
      end
      want = replies_due[0];
      replies_due.delete(0);
      checked++;
      status_seen[want.status]++;
      compare("status", want.status, got.status);
      compare("out_token_count", want.tokens, got.tokens);
      compare("out_tag", want.tag, got.tag);
      compare("out_terminal_code", want.code, got.code);
      compare("lease_release", want.lease, got.lease);
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [1:0]                      action_i;
  logic [tbem_pkg::TOK_W-1:0]      token_count_i;
  logic [tbem_pkg::TAG_BITS-1:0]   delta_tag_i;
  logic [tbem_pkg::CODE_W-1:0]     terminal_code_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [2:0]                      status_o;
  logic [tbem_pkg::TOK_W-1:0]      out_token_count_o;
  logic [tbem_pkg::TAG_BITS-1:0]   out_tag_o;
  logic [tbem_pkg::CODE_W-1:0]     out_terminal_code_o;
  logic                            lease_release_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [tbem_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [tbem_pkg::CFG_DATA_W-1:0] cfg_data_i;

  mailbox_shadow shadow = new();

  // While calm is set neither side inserts random gaps, so words go through back to back.
  bit          calm = 1'b0;
  int unsigned sent_words = 0;
  int unsigned limit_settings = 0;

  token_budget_event_mailbox dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .action_i            (action_i),
    .token_count_i       (token_count_i),
    .delta_tag_i         (delta_tag_i),
    .terminal_code_i     (terminal_code_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .out_token_count_o   (out_token_count_o),
    .out_tag_o           (out_tag_o),
    .out_terminal_code_o (out_terminal_code_o),
    .lease_release_o     (lease_release_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Offer one word. Entered and left just after a falling edge; the valid is left high on
  // return so that the next call can present its word straight away without a gap. A
  // random number of idle cycles may come first, unless the calm stretch is running.
  task automatic send_word(tbem_pkg::action_e act, logic [tbem_pkg::TOK_W-1:0] tok,
                           logic [tbem_pkg::TAG_BITS-1:0] tag,
                           logic [tbem_pkg::CODE_W-1:0] code);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    token_count_i   <= tok;
    delta_tag_i     <= tag;
    terminal_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    shadow.take_word(act, tok, tag, code);
    sent_words++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every reply has come back and the execute stage has emptied,
  // so that the limits may be rewritten with the block at rest.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (shadow.replies_due.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Write both limit registers, one after the other, holding the valid high between them.
  task automatic program_limits(logic [tbem_pkg::CFG_DATA_W-1:0] entries_data,
                                logic [tbem_pkg::CFG_DATA_W-1:0] tokens_data);
    tbem_pkg::reg_idx_e              idx [2];
    logic [tbem_pkg::CFG_DATA_W-1:0] data [2];
    idx[0]  = tbem_pkg::REG_MAX_ENTRIES;
    idx[1]  = tbem_pkg::REG_MAX_TOKENS;
    data[0] = entries_data;
    data[1] = tokens_data;
    for (int i = 0; i < 2; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= data[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      shadow.write_reg(idx[i], data[i]);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    limit_settings++;
  endtask

  // Receiver: a word is taken at each rising edge that sees valid high and stall low, and its
  // stall for the next edge is chosen at the falling edge. Once enough replies have passed it
  // holds off for a long stretch, so that the block fills up and stalls its input while the
  // sender keeps on offering.
  initial begin
    reply_t      got;
    int unsigned hold_left;
    bit          held;
    hold_left   = 0;
    held        = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.status = tbem_pkg::status_e'(status_o);
        got.tokens = out_token_count_o;
        got.tag    = out_tag_o;
        got.code   = out_terminal_code_o;
        got.lease  = lease_release_o;
        shadow.check_reply(got);
      end
      @(negedge clk_i);
      if (!held && shadow.checked >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 29);
      end
    end
  end

  // Watchdog: a run in which nothing is handed over for too long has hung.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned                     random_start;
    int unsigned                     phase;
    int unsigned                     span;
    int unsigned                     push_pct;
    bit                              narrow_tokens;
    logic [tbem_pkg::TOK_W-1:0]      tok;
    logic [tbem_pkg::CFG_DATA_W-1:0] entries_data;
    logic [tbem_pkg::CFG_DATA_W-1:0] tokens_data;

    // Every input is driven from time zero; reset is held low before the first words.
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    action_i        = tbem_pkg::ACT_POP;
    token_count_i   = '0;
    delta_tag_i     = '0;
    terminal_code_i = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = tbem_pkg::REG_MAX_ENTRIES;
    cfg_data_i      = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words on the reset limits (16 entries, 4096 tokens): an empty pop, a zero-token
    // push, the largest count with an all-ones tag, then a push that exactly uses up the
    // budget and one that no longer fits, and the queue drained in order.
    send_word(tbem_pkg::ACT_POP, 12'($urandom), $urandom, 16'($urandom));
    send_word(tbem_pkg::ACT_PUSH_DELTA, '0, $urandom, 16'($urandom));
    send_word(tbem_pkg::ACT_PUSH_DELTA, 12'd4095, '1, 16'($urandom));
    send_word(tbem_pkg::ACT_PUSH_DELTA, 12'd1, '0, 16'($urandom));
    send_word(tbem_pkg::ACT_PUSH_DELTA, 12'd1, $urandom, 16'($urandom));
    send_word(tbem_pkg::ACT_POP, 12'($urandom), $urandom, 16'($urandom));
    send_word(tbem_pkg::ACT_POP, 12'($urandom), $urandom, 16'($urandom));
    send_word(tbem_pkg::ACT_POP, 12'($urandom), $urandom, 16'($urandom));

    // A zero budget refuses every delta.
    settle();
    program_limits(16'd16, 16'd0);
    send_word(tbem_pkg::ACT_PUSH_DELTA, 12'd1, $urandom, 16'($urandom));

    // A single entry allowed: the second push is refused since the entry limit is reached.
    settle();
    program_limits(16'd1, 16'hFFFF);
    send_word(tbem_pkg::ACT_PUSH_DELTA, 12'd4095, 32'hA5A5_A5A5, 16'($urandom));
    send_word(tbem_pkg::ACT_PUSH_DELTA, 12'd7, $urandom, 16'($urandom));

    // No entries allowed at all; the entry already queued is still handed out.
    settle();
    program_limits(16'd0, 16'hFFFF);
    send_word(tbem_pkg::ACT_PUSH_DELTA, 12'd3, $urandom, 16'($urandom));
    send_word(tbem_pkg::ACT_POP, 12'($urandom), $urandom, 16'($urandom));

    // Entry limit with every data bit set, which the register takes as 31 and so as the full
    // depth; then the budget is lowered under what is queued, leaving no room at all.
    settle();
    program_limits(16'hFFFF, 16'hFFFF);
    send_word(tbem_pkg::ACT_PUSH_DELTA, 12'd100, 32'h5A5A_5A5A, 16'($urandom));
    settle();
    program_limits(16'd16, 16'd50);
    send_word(tbem_pkg::ACT_PUSH_DELTA, 12'd1, $urandom, 16'($urandom));
    send_word(tbem_pkg::ACT_POP, 12'($urandom), $urandom, 16'($urandom));

    // Random phases of delta pushes and pops. Each phase gets fresh limits and a push share
    // that either fills the queue, keeps it level or drains it; some phases use small counts
    // so that the entry limit binds, others large ones so that the budget binds. Terminals
    // and close are kept for the end, since both shut the mailbox for good.
    random_start = sent_words;
    phase        = 0;
    while (sent_words - random_start < RANDOM_WORDS) begin
      settle();
      calm = (phase >= 10 && phase < 14);
      case ($urandom_range(9))
        0:       entries_data = 16'd0;
        1:       entries_data = {11'($urandom), 5'($urandom_range(17, 31))};
        default: entries_data = 16'($urandom_range(1, 16));
      endcase
      case ($urandom_range(15))
        0:       tokens_data = 16'd0;
        1, 2:    tokens_data = 16'hFFFF;
        3:       tokens_data = 16'd4096;
        4, 5:    tokens_data = 16'($urandom_range(1, 100));
        default: tokens_data = 16'($urandom_range(1, 65535));
      endcase
      program_limits(entries_data, tokens_data);
      case ($urandom_range(2))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      narrow_tokens = $urandom_range(1);
      span          = $urandom_range(20, 80);
      repeat (span) begin
        if ($urandom_range(99) < push_pct) begin
          if ($urandom_range(19) == 0) begin
            tok = '0;
          end else if (narrow_tokens) begin
            tok = 12'($urandom_range(1, 64));
          end else begin
            tok = 12'($urandom_range(1, 4095));
          end
          send_word(tbem_pkg::ACT_PUSH_DELTA, tok, $urandom, 16'($urandom));
        end else begin
          send_word(tbem_pkg::ACT_POP, 12'($urandom), $urandom, 16'($urandom));
        end
      end
      phase++;
    end

    // Closing sequence: a terminal accepted behind queued deltas, a second terminal and a
    // further delta refused, close while the terminal still waits, the deltas and then the
    // terminal popped, and after that only closed reports, refusals and accepted closes.
    settle();
    calm = 1'b0;
    program_limits(16'd16, 16'hFFFF);
    send_word(tbem_pkg::ACT_PUSH_DELTA, 12'($urandom_range(1, 4095)), $urandom,
              16'($urandom));
    send_word(tbem_pkg::ACT_PUSH_DELTA, 12'($urandom_range(1, 4095)), $urandom,
              16'($urandom));
    send_word(tbem_pkg::ACT_PUSH_TERMINAL, 12'($urandom), $urandom, 16'($urandom));
    send_word(tbem_pkg::ACT_PUSH_TERMINAL, 12'($urandom), $urandom, 16'($urandom));
    send_word(tbem_pkg::ACT_PUSH_DELTA, 12'd5, $urandom, 16'($urandom));
    send_word(tbem_pkg::ACT_CLOSE, 12'($urandom), $urandom, 16'($urandom));
    send_word(tbem_pkg::ACT_PUSH_TERMINAL, 12'($urandom), $urandom, 16'($urandom));
    repeat (4) send_word(tbem_pkg::ACT_POP, 12'($urandom), $urandom, 16'($urandom));
    send_word(tbem_pkg::ACT_CLOSE, 12'($urandom), $urandom, 16'($urandom));
    send_word(tbem_pkg::ACT_PUSH_DELTA, 12'd9, $urandom, 16'($urandom));
    repeat (80) begin
      send_word(tbem_pkg::action_e'($urandom_range(3)), 12'($urandom), $urandom,
                16'($urandom));
    end

    // Let the last replies drain, then wait on for any stray word to show.
    settle();
    repeat (10) @(negedge clk_i);
    if (shadow.replies_due.size() != 0) begin
      shadow.errors++;
      $display("%0t: %0d replies never arrived", $time, shadow.replies_due.size());
    end

    $display("Run sent %0d words over %0d limit settings, with a long receiver hold-off",
             sent_words, limit_settings);
    $display("Replies: %0d accepted, %0d refused, %0d deltas, %0d terminal, %0d closed, %0d idle",
             shadow.status_seen[tbem_pkg::ST_ACCEPTED],
             shadow.status_seen[tbem_pkg::ST_REFUSED],
             shadow.status_seen[tbem_pkg::ST_DELTA],
             shadow.status_seen[tbem_pkg::ST_TERMINAL],
             shadow.status_seen[tbem_pkg::ST_CLOSED],
             shadow.status_seen[tbem_pkg::ST_NOTHING]);
    if (shadow.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
